>>> src/splitmix64_uniform_range_defines.svh
// ---------------------------------------------------------------------------
// splitmix64_uniform_range assertion macros
// concurrent check helpers, empty when SYNTHESIS is set
// ---------------------------------------------------------------------------
`ifndef SPLITMIX64_UNIFORM_RANGE_DEFINES_SVH
`define SPLITMIX64_UNIFORM_RANGE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SMR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smr check failed");
// next-cycle implication
`define SMR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smr check failed");
`else
`define SMR_ASSERT_NOW(label, ante, cons)
`define SMR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> src/smr_pkg.sv
// ---------------------------------------------------------------------------
// smr_pkg
// constants shared by the splitmix64 range generator
// ---------------------------------------------------------------------------
`default_nettype none

package smr_pkg;

  localparam int          UNIT_BITS_DEF = 24;
  localparam logic [63:0] GOLDEN_STEP   = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A     = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B     = 64'h94D0_49BB_1331_11EB;

  localparam int SHIFT_A = 30;
  localparam int SHIFT_B = 27;
  localparam int SHIFT_C = 31;

  // apb map: one 64-bit register at byte address 0
  localparam int   ADDR_W   = 4;
  localparam logic REG_SEED = 1'b0;

  localparam int VALUE_W = 32;
  localparam int UNIT_W  = 24;
  localparam int WORD_W  = 64;

endpackage

`default_nettype wire

>>> src/splitmix64_uniform_range.sv
// ---------------------------------------------------------------------------
// splitmix64_uniform_range
// splitmix64 generator scaled onto a signed q16.16 range
// ---------------------------------------------------------------------------
//
//   channel | handshake                | payload
//   --------+--------------------------+------------------------------------
//   input   | in_valid / in_ready      | range_min, range_max
//   output  | out_valid / out_ready    | value, unit_bits, raw_word,
//           |                          | range_error
//   config  | apb psel/penable/pwrite  | seed (64 bit, address 0)
//
// a draw runs from transfer to result through one state step, the two
// 64-bit mix multiplies and the range scaling, all on a single shared
// 32x32 multiplier, then a final load of the result. an empty or
// reversed range skips the multiplier and goes straight to that load.
// in_ready is high only while the sequencer idles; a result held by a
// stalled output does not block the next input transfer, only the final
// load of the following result. reset (synchronous) loads seed and state
// with zero; a seed write reloads the state.
//
`default_nettype none
`include "splitmix64_uniform_range_defines.svh"

module splitmix64_uniform_range #(
  parameter int UNIT_BITS = smr_pkg::UNIT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // request channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [smr_pkg::VALUE_W-1:0] range_min,
  input  wire logic signed [smr_pkg::VALUE_W-1:0] range_max,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [smr_pkg::VALUE_W-1:0]   value,
  output logic        [smr_pkg::UNIT_W-1:0]    unit_bits,
  output logic        [smr_pkg::WORD_W-1:0]    raw_word,
  output logic                                 range_error,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic   [smr_pkg::ADDR_W-1:0]    paddr,
  input  wire logic   [smr_pkg::WORD_W-1:0]    pwdata,
  output logic        [smr_pkg::WORD_W-1:0]    prdata,
  output logic                                 pready
);
  import smr_pkg::*;

  localparam int FRAC_SHIFT = WORD_W - UNIT_BITS;

  // sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_STEP  = 3'd1;
  localparam logic [2:0] ST_MULA  = 3'd2;
  localparam logic [2:0] ST_MULB  = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;
  localparam logic [1:0] PH_3 = 2'd3;

  logic [2:0]         state;
  logic [1:0]         phase;
  logic [WORD_W-1:0]  seed;
  logic [WORD_W-1:0]  gen_state;
  logic [WORD_W-1:0]  mix_z;       // operand of the current mix multiply
  logic [WORD_W-1:0]  acc;         // 64-bit low product accumulator
  logic [WORD_W-1:0]  prod;        // registered multiplier output
  logic [95:0]        sum;         // span * frac, full width
  logic [WORD_W-1:0]  raw_q;
  logic [VALUE_W-1:0] min_q;
  logic [VALUE_W-1:0] span;
  logic               err_q;
  logic               eq_q;

  logic               cfg_wr;
  logic               in_xfer;
  logic               out_free;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [WORD_W-1:0]  mul_p;
  logic [WORD_W-1:0]  mul_k;
  logic [WORD_W-1:0]  frac;
  logic [WORD_W-1:0]  step_x;
  logic [WORD_W-1:0]  mix_m;
  logic [VALUE_W-1:0] offset;

  function automatic logic err_next(input logic signed [VALUE_W-1:0] lo,
                                    input logic signed [VALUE_W-1:0] hi);
    return lo > hi;
  endfunction

  function automatic logic eq_next(input logic signed [VALUE_W-1:0] lo,
                                   input logic signed [VALUE_W-1:0] hi);
    return lo == hi;
  endfunction

  // apb: always ready, write lands in the access phase
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr[ADDR_W-1] == REG_SEED);
  assign prdata  = (paddr[ADDR_W-1] == REG_SEED) ? seed : '0;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // top bits of the mixed word as the unit fraction
  assign frac   = raw_q >> FRAC_SHIFT;
  assign offset = sum[UNIT_BITS +: VALUE_W];
  assign step_x = gen_state + GOLDEN_STEP;
  // high word gets the last cross partial product
  assign mix_m  = {acc[63:32] + prod[31:0], acc[31:0]};
  assign mul_k  = (state == ST_MULB) ? MIX_MUL_B : MIX_MUL_A;

  // shared multiplier operand select
  always_comb begin
    mul_a = mix_z[31:0];
    mul_b = mul_k[31:0];
    if (state == ST_SCALE) begin
      mul_a = span;
      mul_b = (phase == PH_0) ? frac[31:0] : frac[63:32];
    end else begin
      case (phase)
        PH_1:    mul_b = mul_k[63:32];
        PH_2:    mul_a = mix_z[63:32];
        default: mul_b = mul_k[31:0];
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod <= mul_p;
  end

  // seed register and generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= '0;
      gen_state <= '0;
    end else if (cfg_wr) begin
      seed      <= pwdata;
      gen_state <= pwdata;
    end else if (state == ST_STEP) begin
      gen_state <= step_x;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_0;
      out_valid <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          phase <= PH_0;
          if (in_xfer) begin
            state <= (eq_next(range_min, range_max) || err_next(range_min, range_max))
                     ? ST_FIN : ST_STEP;
          end
        end
        ST_STEP: begin
          state <= ST_MULA;
          phase <= PH_0;
        end
        ST_MULA, ST_MULB: begin
          phase <= phase + 2'd1;
          if (phase == PH_3) begin
            state <= (state == ST_MULA) ? ST_MULB : ST_SCALE;
          end
        end
        ST_SCALE: begin
          phase <= phase + 2'd1;
          if (phase == PH_2) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      min_q <= range_min;
      span  <= range_max - range_min;
      err_q <= err_next(range_min, range_max);
      eq_q  <= eq_next(range_min, range_max);
    end
    case (state)
      ST_STEP: begin
        mix_z <= step_x ^ (step_x >> SHIFT_A);
      end
      ST_MULA, ST_MULB: begin
        case (phase)
          PH_1: acc <= prod;
          PH_2: acc[63:32] <= acc[63:32] + prod[31:0];
          PH_3: begin
            if (state == ST_MULA) begin
              mix_z <= mix_m ^ (mix_m >> SHIFT_B);
            end else begin
              raw_q <= mix_m ^ (mix_m >> SHIFT_C);
            end
          end
          default: ;
        endcase
      end
      ST_SCALE: begin
        if (phase == PH_1) begin
          sum <= {32'b0, prod};
        end else if (phase == PH_2) begin
          sum[95:32] <= sum[95:32] + prod;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      range_error <= err_q;
      if (err_q) begin
        value <= '0;
      end else if (eq_q) begin
        value <= min_q;
      end else begin
        value <= min_q + offset;
      end
      unit_bits <= (err_q || eq_q) ? '0 : frac[UNIT_W-1:0];
      raw_word  <= (err_q || eq_q) ? '0 : raw_q;
    end
  end

  // checks
  `SMR_ASSERT_NEXT(a_xfer_leaves_idle, in_xfer, state != ST_IDLE)
  `SMR_ASSERT_NEXT(a_state_only_steps, !cfg_wr && state != ST_STEP, $stable(gen_state))
  `SMR_ASSERT_NOW(a_error_clean, out_valid && range_error, {value, unit_bits, raw_word} == '0)
  `SMR_ASSERT_NEXT(a_fin_loads, state == ST_FIN && out_free, out_valid && state == ST_IDLE)

endmodule

`default_nettype wire

>>> tb/tb_splitmix64_uniform_range.sv
// ---------------------------------------------------------------------------
// tb_splitmix64_uniform_range
// self-checking bench for the splitmix64 range generator: requests are
// predicted in step with an internal copy of the generator state, results
// are checked field by field in order, the seed register is loaded over apb
// between phases, and both handshakes idle and stall at random
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_splitmix64_uniform_range;

  import smr_pkg::*;

  localparam int UNIT_BITS      = UNIT_BITS_DEF;
  localparam int DRAW_LATENCY   = 13;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int RANDOM_PHASES  = 5;

  // register map: one 64-bit register per 8-byte slot
  localparam int                 SEED_INDEX = REG_SEED;
  localparam logic [ADDR_W-1:0]  SEED_ADDR  = ADDR_W'(8 * SEED_INDEX);
  localparam logic [ADDR_W-1:0]  SPARE_ADDR = ADDR_W'(8 * (SEED_INDEX + 1));

  localparam logic signed [VALUE_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] Q_ONE = 32'sh0001_0000;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic        [UNIT_W-1:0]  unit_bits;
    logic        [WORD_W-1:0]  raw_word;
    logic                      range_error;
  } draw_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic signed [VALUE_W-1:0] range_min = '0;
  logic signed [VALUE_W-1:0] range_max = '0;

  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] value;
  logic        [UNIT_W-1:0]  unit_bits;
  logic        [WORD_W-1:0]  raw_word;
  logic                      range_error;

  logic                      psel    = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite  = 1'b0;
  logic        [ADDR_W-1:0]  paddr   = '0;
  logic        [WORD_W-1:0]  pwdata  = '0;
  logic        [WORD_W-1:0]  prdata;
  logic                      pready;

  // bench copy of the generator and its register
  logic [WORD_W-1:0] model_seed  = '0;
  logic [WORD_W-1:0] model_state = '0;
  draw_t             pending_draws[$];

  // when set, neither side inserts idle cycles
  bit no_gaps = 1'b0;

  int n_fail       = 0;
  int n_checked    = 0;
  int n_draws      = 0;
  int n_reversed   = 0;
  int n_empty      = 0;
  int n_seed_loads = 0;
  int idle_run     = 0;

  splitmix64_uniform_range DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .range_min   (range_min),
    .range_max   (range_max),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .unit_bits   (unit_bits),
    .raw_word    (raw_word),
    .range_error (range_error),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // prediction
  // -------------------------------------------------------------------------

  // one request against the bench state; an empty or reversed range leaves
  // the state alone, otherwise it steps, mixes and scales onto the range
  function automatic draw_t predict_draw(input logic signed [VALUE_W-1:0] lo,
                                         input logic signed [VALUE_W-1:0] hi);
    draw_t        d;
    logic [63:0]  z;
    logic [63:0]  frac;
    logic [32:0]  span;
    logic [127:0] prod;
    d = '0;
    if (lo > hi) begin
      d.range_error = 1'b1;
    end else if (lo == hi) begin
      d.value = lo;
    end else begin
      model_state = model_state + GOLDEN_STEP;
      z = model_state;
      z = (z ^ (z >> SHIFT_A)) * MIX_MUL_A;
      z = (z ^ (z >> SHIFT_B)) * MIX_MUL_B;
      z = z ^ (z >> SHIFT_C);
      frac = z >> (64 - UNIT_BITS);
      // span fits in 33 bits signed, always positive here
      span = {hi[31], hi} - {lo[31], lo};
      prod = {95'd0, span} * {64'd0, frac};
      // offset is below the span, so the sum wraps back into range
      d.value     = lo + prod[UNIT_BITS +: 32];
      d.unit_bits = frac[UNIT_W-1:0];
      d.raw_word  = z;
    end
    return d;
  endfunction

  // -------------------------------------------------------------------------
  // request side
  // -------------------------------------------------------------------------

  // one request transfer, with a random hold-off before valid rises;
  // valid is left high so a back-to-back request needs no extra edge
  task automatic send_range(input logic signed [VALUE_W-1:0] lo,
                            input logic signed [VALUE_W-1:0] hi);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    range_min <= lo;
    range_max <= hi;
    do @(posedge clk); while (!(in_valid && in_ready));
    pending_draws.push_back(predict_draw(lo, hi));
    if (lo > hi) n_reversed++;
    else if (lo == hi) n_empty++;
    else n_draws++;
  endtask

  // drop valid and let every outstanding result arrive
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // apb side: transfers may run back to back, apb_park ends a burst
  // -------------------------------------------------------------------------

  task automatic apb_access(input logic [ADDR_W-1:0] addr, input logic wr,
                            input logic [WORD_W-1:0] wdata,
                            output logic [WORD_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr && addr == SEED_ADDR) begin
      model_seed  = wdata;
      model_state = wdata;
      n_seed_loads++;
    end
  endtask

  task automatic apb_park();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // load a seed and read it straight back
  task automatic load_seed(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] rd;
    apb_access(SEED_ADDR, 1'b1, s, rd);
    apb_access(SEED_ADDR, 1'b0, '0, rd);
    apb_park();
    if (rd !== model_seed) begin
      $error("seed readback: expected %h, got %h", model_seed, rd);
      n_fail++;
    end
  endtask

  // -------------------------------------------------------------------------
  // result side
  // -------------------------------------------------------------------------

  // ready drops for a random stall before each result
  initial begin : result_sink
    int stall;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin : check_results
    draw_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_draws.size() == 0) begin
        $error("result transfer with no request outstanding");
        n_fail++;
      end else begin
        want = pending_draws.pop_front();
        n_checked++;
        if (value !== want.value) begin
          $error("value: expected %h, got %h", want.value, value);
          n_fail++;
        end
        if (unit_bits !== want.unit_bits) begin
          $error("unit_bits: expected %h, got %h", want.unit_bits, unit_bits);
          n_fail++;
        end
        if (raw_word !== want.raw_word) begin
          $error("raw_word: expected %h, got %h", want.raw_word, raw_word);
          n_fail++;
        end
        if (range_error !== want.range_error) begin
          $error("range_error: expected %b, got %b", want.range_error, range_error);
          n_fail++;
        end
      end
    end
  end

  // a run of cycles with no transfer on any port means the block is stuck
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("FAIL splitmix64_uniform_range");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // tests
  // -------------------------------------------------------------------------

  // seed register comes out of reset as zero and the state follows it
  task automatic test_reset_state();
    logic [WORD_W-1:0] rd;
    apb_access(SEED_ADDR, 1'b0, '0, rd);
    apb_park();
    if (rd !== '0) begin
      $error("seed after reset: expected %h, got %h", 64'd0, rd);
      n_fail++;
    end
  endtask

  // range extremes, empty and reversed ranges, drawn from the reset state;
  // skipped draws in between show that the state holds still
  task automatic test_range_corners();
    send_range('0, Q_ONE);
    send_range(Q_MIN, Q_MAX);
    send_range(Q_MAX, Q_MIN);
    send_range(Q_MIN, Q_MIN + 1);
    send_range(Q_MAX - 1, Q_MAX);
    send_range('0, '0);
    send_range(-Q_ONE, Q_ONE);
    send_range(Q_MIN, Q_MIN);
    send_range(Q_MAX, Q_MAX);
    send_range(Q_MIN, '0);
    send_range(32'sd1, '0);
    send_range('0, Q_MAX);
    send_range(-32'sd1, -32'sd1);
    send_range(-32'sd1, Q_MIN);
    send_range(32'sh8AAA_AAAA, 32'sh5555_5555);
    settle();
  endtask

  // seed loads at the edges of the 64-bit space, then a write to an
  // unmapped slot that must leave seed and state alone
  task automatic test_seed_loads();
    logic [WORD_W-1:0] seeds[5];
    logic [WORD_W-1:0] rd;
    seeds[0] = '1;
    seeds[1] = 64'h8000_0000_0000_0000;
    seeds[2] = 64'd0 - GOLDEN_STEP;  // first step lands the state on zero
    seeds[3] = {$urandom, $urandom};
    seeds[4] = '0;
    foreach (seeds[i]) begin
      load_seed(seeds[i]);
      send_range(Q_MIN, Q_MAX);
      send_range(-Q_ONE, Q_ONE);
      settle();
    end
    apb_access(SPARE_ADDR, 1'b1, {$urandom, $urandom}, rd);
    apb_access(SEED_ADDR, 1'b0, '0, rd);
    apb_park();
    if (rd !== model_seed) begin
      $error("seed after unmapped write: expected %h, got %h", model_seed, rd);
      n_fail++;
    end
    send_range(Q_MIN, Q_MAX);
    settle();
  endtask

  // bounds lean towards the extremes and small q16.16 values
  function automatic logic signed [VALUE_W-1:0] pick_bound();
    case ($urandom_range(0, 7))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
      3:       return ($signed($urandom_range(0, 200)) - 100) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  // mostly proper ranges, with empty and reversed ones mixed in
  task automatic random_request();
    logic signed [VALUE_W-1:0] a;
    logic signed [VALUE_W-1:0] b;
    logic signed [VALUE_W-1:0] t;
    int kind;
    a = pick_bound();
    b = pick_bound();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      b = a;
    end else begin
      if (a == b) b = a ^ 32'sd1;
      // reversed for a few, ordered for the rest
      if ((kind < 24) == (a < b)) begin
        t = a;
        a = b;
        b = t;
      end
    end
    send_range(a, b);
  endtask

  // random traffic in phases with a fresh seed before each; the middle
  // phase runs with no idling on either side
  task automatic test_random_traffic();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_seed({$urandom, $urandom});
      no_gaps = (p == RANDOM_PHASES / 2);
      repeat (RANDOM_ITEMS / RANDOM_PHASES) random_request();
      settle();
    end
    no_gaps = 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // sequence
  // -------------------------------------------------------------------------

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_range_corners();
    test_seed_loads();
    test_random_traffic();
    // let any stray result show up before the verdict
    repeat (2 * DRAW_LATENCY) @(posedge clk);
    $display("covered %0d draws, %0d empty and %0d reversed ranges, %0d seed loads",
             n_draws, n_empty, n_reversed, n_seed_loads);
    $display("checked %0d results, %0d mismatches", n_checked, n_fail);
    if (n_fail == 0 && pending_draws.size() == 0) begin
      $display("PASS splitmix64_uniform_range");
    end else begin
      $display("FAIL splitmix64_uniform_range");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/smr_pkg.sv
src/splitmix64_uniform_range.sv
tb/tb_splitmix64_uniform_range.sv
